>>> src/rfbf_pkg.sv
package rfbf_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FIXED   = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    localparam logic [1:0] ROLE_TYPE    = 2'd0;
    localparam logic [1:0] ROLE_FIXED   = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_DISCARD = 2'd3;

    localparam logic [2:0] TYPE_COLOURS   = 3'd1;
    localparam logic [2:0] TYPE_ENCODINGS = 3'd2;
    localparam logic [2:0] TYPE_CUT_TEXT  = 3'd6;
    localparam logic [7:0] TYPE_MAX       = 8'd6;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  message_type;
        logic [1:0]  byte_role;
        logic [4:0]  fixed_position;
        logic [31:0] payload_length;
        logic        message_done;
        logic        protocol_error;
    } t_result;

    // fixed part length, type byte included
    function automatic logic [4:0] fixed_len(input logic [2:0] t);
        logic [4:0] len;
        case (t)
            3'd0:    len = 5'd20;
            3'd1:    len = 5'd6;
            3'd2:    len = 5'd4;
            3'd3:    len = 5'd10;
            3'd4:    len = 5'd8;
            3'd5:    len = 5'd6;
            3'd6:    len = 5'd8;
            default: len = 5'd20;
        endcase
        return len;
    endfunction

    function automatic logic is_length_byte(input logic [2:0] t, input logic [4:0] pos);
        logic hit;
        case (t)
            TYPE_COLOURS:   hit = (pos == 5'd4) || (pos == 5'd5);
            TYPE_ENCODINGS: hit = (pos == 5'd2) || (pos == 5'd3);
            TYPE_CUT_TEXT:  hit = (pos >= 5'd4) && (pos <= 5'd7);
            default:        hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [31:0] payload_of(input logic [2:0] t, input logic [31:0] cap);
        logic [31:0] cnt;
        logic [31:0] plen;
        cnt = {16'd0, cap[15:0]};
        case (t)
            TYPE_COLOURS:   plen = (cnt << 2) + (cnt << 1);
            TYPE_ENCODINGS: plen = cnt << 2;
            TYPE_CUT_TEXT:  plen = cap;
            default:        plen = 32'd0;
        endcase
        return plen;
    endfunction

endpackage

>>> src/rfbf_framer.sv
module rfbf_framer
    import rfbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_segment_end,
    output t_result    o_res
);

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_type,    n_type;
    logic [4:0]  r_count,   n_count;
    logic [31:0] r_cap,     n_cap;
    logic [31:0] r_left,    n_left;
    logic [31:0] r_plen,    n_plen;
    logic        r_discard, n_discard;

    logic [31:0] fix_cap;
    logic [4:0]  fix_count;
    logic        fix_end;
    logic [31:0] fix_plen;
    logic [31:0] pay_left;

    always_comb begin
        fix_cap   = is_length_byte(r_type, r_count) ? {r_cap[23:0], i_data_byte} : r_cap;
        fix_count = r_count + 5'd1;
        fix_end   = (fix_count >= fixed_len(r_type));
        fix_plen  = payload_of(r_type, fix_cap);
        pay_left  = r_left - 32'd1;
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_count   = r_count;
        n_cap     = r_cap;
        n_left    = r_left;
        n_plen    = r_plen;
        n_discard = r_discard;
        if (r_discard) begin
            if (i_segment_end) n_discard = 1'b0;
        end else begin
            case (r_phase)
                PH_FIXED: begin
                    n_cap   = fix_cap;
                    n_count = fix_count;
                    if (fix_end) begin
                        n_plen = fix_plen;
                        if (fix_plen == 32'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_left  = fix_plen;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_left = pay_left;
                    if (pay_left == 32'd0) n_phase = PH_IDLE;
                end
                default: begin
                    if (i_data_byte > TYPE_MAX) begin
                        n_phase = PH_IDLE;
                        if (!i_segment_end) n_discard = 1'b1;
                    end else begin
                        n_type  = i_data_byte[2:0];
                        n_count = 5'd1;
                        n_cap   = 32'd0;
                        n_left  = 32'd0;
                        n_phase = PH_FIXED;
                    end
                end
            endcase
        end
    end

    // result of the current item
    always_comb begin
        o_res                = '0;
        o_res.byte_value     = i_data_byte;
        if (r_discard) begin
            o_res.byte_role = ROLE_DISCARD;
        end else begin
            case (r_phase)
                PH_FIXED: begin
                    o_res.message_type   = r_type;
                    o_res.byte_role      = ROLE_FIXED;
                    o_res.fixed_position = r_count;
                    if (fix_end) begin
                        o_res.payload_length = fix_plen;
                        o_res.message_done   = (fix_plen == 32'd0);
                    end
                end
                PH_PAYLOAD: begin
                    o_res.message_type   = r_type;
                    o_res.byte_role      = ROLE_PAYLOAD;
                    o_res.payload_length = r_plen;
                    o_res.message_done   = (pay_left == 32'd0);
                end
                default: begin
                    o_res.byte_role = ROLE_TYPE;
                    if (i_data_byte > TYPE_MAX) begin
                        o_res.protocol_error = 1'b1;
                    end else begin
                        o_res.message_type = i_data_byte[2:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_type    <= 3'd0;
            r_count   <= 5'd0;
            r_cap     <= 32'd0;
            r_left    <= 32'd0;
            r_plen    <= 32'd0;
            r_discard <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_count   <= n_count;
            r_cap     <= n_cap;
            r_left    <= n_left;
            r_plen    <= n_plen;
            r_discard <= n_discard;
        end
    end

endmodule

>>> src/rfb_client_message_framer_core.sv
// A byte passes through the input register and then the result register on its way to the
// outputs. Throughput: one byte per cycle while i_out_stall is low; framing state advances as
// an item moves into the result register, so back-to-back bytes see each other's updates with
// no bubble.
// Reset (synchronous, active low): both registers empty, framer idle awaiting a
// type byte, discard flag clear.
module rfb_client_message_framer_core
    import rfbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_segment_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_message_type,
    output logic [1:0]  o_byte_role,
    output logic [4:0]  o_fixed_position,
    output logic [31:0] o_payload_length,
    output logic        o_message_done,
    output logic        o_protocol_error
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_seg;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    logic       move;
    logic       in_take;

    // item leaves the input register when the result register is free or draining
    assign move    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !move;

    rfbf_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (move),
        .i_data_byte   (r_in_byte),
        .i_segment_end (r_in_seg),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take)   r_in_valid <= 1'b1;
            else if (move) r_in_valid <= 1'b0;
            if (move)              r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_seg  <= i_segment_end;
        end
        if (move) r_out <= step_res;
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_value     = r_out.byte_value;
    assign o_message_type   = r_out.message_type;
    assign o_byte_role      = r_out.byte_role;
    assign o_fixed_position = r_out.fixed_position;
    assign o_payload_length = r_out.payload_length;
    assign o_message_done   = r_out.message_done;
    assign o_protocol_error = r_out.protocol_error;

endmodule
